>>> hw/rtl/mspa_pkg.sv
// Shared types and constants for the MIDI system message assembler.
package mspa_pkg;

    localparam int PORT_COUNT_DEFAULT     = 16;
    localparam int SYSEX_DATA_MAX_DEFAULT = 62;

    localparam int SLOTS       = 64;
    localparam int SLOT_W      = 6;
    localparam int LEN_W       = 7;
    localparam int REM_W       = 6;
    localparam int DATA_LIMIT  = 128;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_MTC     = 8'hF1;
    localparam logic [7:0] ST_SPP     = 8'hF2;
    localparam logic [7:0] ST_SONG    = 8'hF3;
    localparam logic [7:0] ST_TUNE    = 8'hF6;
    localparam logic [7:0] ST_EOX     = 8'hF7;
    localparam logic [7:0] RT_CLOCK   = 8'hF8;
    localparam logic [7:0] RT_START   = 8'hFA;
    localparam logic [7:0] RT_CONT    = 8'hFB;
    localparam logic [7:0] RT_STOP    = 8'hFC;
    localparam logic [7:0] RT_SENSE   = 8'hFE;
    localparam logic [7:0] RT_RESET   = 8'hFF;

    typedef struct packed {
        logic [3:0] port;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [3:0] out_port;
        logic [7:0] out_byte;
        logic       last;
    } t_out;

    typedef struct packed {
        logic             is_flush;
        logic [3:0]       port;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [3:0]        port;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic       en;
        logic [3:0] port;
    } t_done;

endpackage

>>> hw/rtl/mspa_front.sv
// Front end: classifies input words, tracks per-port message state and writes the store.
module mspa_front
    import mspa_pkg::*;
#(
    parameter int PORT_COUNT     = PORT_COUNT_DEFAULT,
    parameter int SYSEX_DATA_MAX = SYSEX_DATA_MAX_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_in   i_in,
    input  logic  i_q_full,
    output logic  o_push,
    output t_cmd  o_push_cmd,
    output t_wr   o_wr,
    input  t_done i_done
);

    localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam logic [4:0] PORT_LIMIT = 5'(PORT_COUNT);

    typedef enum logic [2:0] {
        K_RT,
        K_OPEN,
        K_END,
        K_DATA,
        K_IGN
    } t_kind;

    logic             r_open    [PORT_COUNT];
    logic [REM_W-1:0] r_rem     [PORT_COUNT];
    logic [LEN_W-1:0] r_len     [PORT_COUNT];
    logic [PORT_COUNT-1:0] r_pending;
    logic [PORT_COUNT-1:0] n_pending;

    t_kind             kind;
    logic [REM_W-1:0]  need;
    logic [PIDX_W-1:0] pidx;
    logic              in_range;
    logic              acc;
    logic              cur_open;
    logic [REM_W-1:0]  cur_rem;
    logic [LEN_W-1:0]  cur_len;
    logic              can_app;
    logic [LEN_W-1:0]  app_len;
    logic [REM_W-1:0]  rem_dec;
    logic              do_open;
    logic              do_end;
    logic              do_data;
    logic              do_flush;

    always_comb begin
        kind = K_IGN;
        need = '0;
        unique case (i_in.data_byte) inside
            ST_TUNE, RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE, RT_RESET: begin
                kind = K_RT;
            end
            ST_MTC, ST_SONG: begin
                kind = K_OPEN;
                need = REM_W'(1);
            end
            ST_SPP: begin
                kind = K_OPEN;
                need = REM_W'(2);
            end
            ST_SYSEX: begin
                kind = K_OPEN;
                need = REM_W'(SYSEX_DATA_MAX);
            end
            ST_EOX: begin
                kind = K_END;
            end
            default: begin
                if (i_in.data_byte < 8'(DATA_LIMIT)) begin
                    kind = K_DATA;
                end
            end
        endcase
    end

    always_comb begin
        pidx     = i_in.port[PIDX_W-1:0];
        in_range = {1'b0, i_in.port} < PORT_LIMIT;
        cur_open = in_range ? r_open[pidx] : 1'b0;
        cur_rem  = in_range ? r_rem[pidx] : '0;
        cur_len  = in_range ? r_len[pidx] : '0;
        can_app  = cur_len < LEN_W'(SLOTS);
        app_len  = can_app ? cur_len + LEN_W'(1) : cur_len;
        rem_dec  = (cur_rem != '0) ? cur_rem - REM_W'(1) : '0;

        o_stall  = i_q_full || (in_range && kind != K_RT && r_pending[pidx]);
        acc      = i_valid && !o_stall;

        do_open  = acc && in_range && kind == K_OPEN;
        do_end   = acc && in_range && kind == K_END && cur_open;
        do_data  = acc && in_range && kind == K_DATA && cur_open;
        do_flush = do_end || (do_data && rem_dec == '0);

        o_push              = (acc && kind == K_RT) || do_flush;
        o_push_cmd.is_flush = do_flush;
        o_push_cmd.port     = i_in.port;
        o_push_cmd.data     = i_in.data_byte;
        o_push_cmd.len      = app_len;

        o_wr.en   = do_open || ((do_end || do_data) && can_app);
        o_wr.port = i_in.port;
        o_wr.slot = do_open ? '0 : cur_len[SLOT_W-1:0];
        o_wr.data = i_in.data_byte;
    end

    always_comb begin
        n_pending = r_pending;
        if (i_done.en) begin
            n_pending[i_done.port[PIDX_W-1:0]] = 1'b0;
        end
        if (do_flush) begin
            n_pending[pidx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_open[p] <= 1'b0;
                r_rem[p]  <= '0;
                r_len[p]  <= '0;
            end
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
            if (do_open) begin
                r_open[pidx] <= 1'b1;
                r_rem[pidx]  <= need;
                r_len[pidx]  <= LEN_W'(1);
            end else if (do_flush) begin
                r_open[pidx] <= 1'b0;
                r_rem[pidx]  <= '0;
                r_len[pidx]  <= '0;
            end else if (do_data) begin
                r_len[pidx] <= app_len;
                r_rem[pidx] <= rem_dec;
            end
        end
    end

endmodule

>>> hw/rtl/mspa_queue.sv
// Small command queue between the front end and the readout engine.
module mspa_queue
    import mspa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/mspa_back.sv
// Readout engine: holds the message store and sends completed messages one word at a time.
module mspa_back
    import mspa_pkg::*;
#(
    parameter int PORT_COUNT = PORT_COUNT_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_wr   i_wr,
    input  t_cmd  i_head,
    input  logic  i_empty,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_out,
    output t_done o_done
);

    localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    logic [7:0] r_mem [PORT_COUNT * SLOTS];
    logic [7:0] r_rd_data;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] n_idx;
    logic             more;
    logic             out_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.port[PIDX_W-1:0], i_wr.slot}] <= i_wr.data;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[{r_cmd.port[PIDX_W-1:0], r_idx[SLOT_W-1:0]}];
        end
    end

    always_comb begin
        n_idx          = r_idx + LEN_W'(1);
        more           = r_cmd.is_flush && (n_idx < r_cmd.len);
        o_valid        = (r_state == S_OUT);
        out_acc        = o_valid && !i_stall;
        o_pop          = (r_state == S_IDLE) && !i_empty;
        o_out.out_port = r_cmd.port;
        o_out.out_byte = r_cmd.is_flush ? r_rd_data : r_cmd.data;
        o_out.last     = !more;
        o_done.en      = out_acc && r_cmd.is_flush && !more;
        o_done.port    = r_cmd.port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_head;
                        r_idx   <= '0;
                        r_state <= i_head.is_flush ? S_READ : S_OUT;
                    end
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (more) begin
                            r_idx   <= n_idx;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.en |-> (o_out.last && out_acc))
        else $error("done signaled away from the final word of a message");

    a_read_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_OUT))
        else $error("store read not followed by output");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_cmd.is_flush) |-> (r_idx < r_cmd.len))
        else $error("readout index beyond message length");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("command popped without starting readout");
`endif

endmodule

>>> hw/rtl/midi_system_message_assembler.sv
// Top level of the MIDI system message assembler.
//
// Input channel: one word per MIDI byte, tagged with its port (i_in, i_in_valid,
// o_in_stall). Output channel: one word per message byte with its port and a
// last flag (o_out, o_out_valid, i_out_stall). A word moves when valid is high
// and stall is low.
// Real-time bytes and tune request are sent on as one-word messages. System
// common and exclusive messages are collected per port in a 64-byte store slot
// and sent once they complete.
// A one-word message passes through the command queue and the readout state register.
// A completed message is queued by its final input word; each of its words then
// passes through the registered store read before it is sent.
// Input words are taken every cycle while the four-entry command queue has room;
// a word that would touch a port whose message is still queued or being read out waits.
// When the receiver stalls, the current output word holds and the queue fills.
// Reset is synchronous and clears all open messages, the queue and the readout.
module midi_system_message_assembler
    import mspa_pkg::*;
#(
    parameter int PORT_COUNT     = PORT_COUNT_DEFAULT,
    parameter int SYSEX_DATA_MAX = SYSEX_DATA_MAX_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic  push;
    t_cmd  push_cmd;
    logic  pop;
    t_cmd  head;
    logic  q_empty;
    logic  q_full;
    t_wr   wr;
    t_done done;

    mspa_front #(
        .PORT_COUNT     (PORT_COUNT),
        .SYSEX_DATA_MAX (SYSEX_DATA_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_cmd (push_cmd),
        .o_wr       (wr),
        .i_done     (done)
    );

    mspa_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    mspa_back #(
        .PORT_COUNT (PORT_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_out   (o_out),
        .o_done  (done)
    );

endmodule

>>> dv/midi_system_message_assembler_tb.sv
// Testbench for the MIDI system message assembler: queued stimulus, in-order prediction and checking.
module midi_system_message_assembler_tb
    import mspa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PORTS         = PORT_COUNT_DEFAULT;
    localparam int SYSEX_BUDGET  = SYSEX_DATA_MAX_DEFAULT;
    localparam int IDLE_PCT      = 11;
    localparam int RANDOM_ITEMS  = 90;
    localparam int CALM_FIRST    = 60;
    localparam int CALM_LAST     = 100;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_PITCH_TOP = 8'hEF;
    localparam logic [7:0] ST_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5  = 8'hF5;
    localparam logic [7:0] ST_UNDEF_F9  = 8'hF9;
    localparam logic [7:0] ST_UNDEF_FD  = 8'hFD;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in        = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    midi_system_message_assembler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    t_in  pending_words[$];
    t_out expected_bytes[$];

    logic             port_open [PORTS];
    logic [REM_W-1:0] port_need [PORTS];
    logic [LEN_W-1:0] port_len  [PORTS];
    logic [7:0]       port_bytes[PORTS][SLOTS];

    int   mismatches     = 0;
    int   words_taken    = 0;
    int   bytes_checked  = 0;
    int   messages_seen  = 0;
    int   planned_count  = 0;
    int   cycle_count    = 0;
    logic calm_phase     = 1'b0;

    initial begin
        for (int p = 0; p < PORTS; p++) begin
            port_open[p] = 1'b0;
            port_need[p] = '0;
            port_len[p]  = '0;
        end
    end

    function automatic bit is_realtime(input logic [7:0] b);
        case (b)
            ST_TUNE, RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE, RT_RESET: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void expect_byte(input logic [3:0] p, input logic [7:0] b,
                                        input logic last);
        t_out r;
        r.out_port = p;
        r.out_byte = b;
        r.last     = last;
        expected_bytes.insert(expected_bytes.size(), r);
    endfunction

    function automatic void open_message(input logic [3:0] p, input logic [7:0] opener,
                                         input int need);
        port_open[p]     = 1'b1;
        port_need[p]     = need[REM_W-1:0];
        port_bytes[p][0] = opener;
        port_len[p]      = LEN_W'(1);
    endfunction

    function automatic void append_byte(input logic [3:0] p, input logic [7:0] b);
        if (port_len[p] < SLOTS) begin
            port_bytes[p][port_len[p]] = b;
            port_len[p] = port_len[p] + LEN_W'(1);
        end
    endfunction

    function automatic void flush_message(input logic [3:0] p);
        int len;
        len = int'(port_len[p]);
        for (int i = 0; i < len; i++)
            expect_byte(p, port_bytes[p][i], (i + 1 == len));
        port_open[p] = 1'b0;
        port_need[p] = '0;
        port_len[p]  = '0;
    endfunction

    function automatic void assemble_word(input t_in w);
        logic [3:0] p;
        logic [7:0] b;
        p = w.port;
        b = w.data_byte;
        if (is_realtime(b)) begin
            expect_byte(p, b, 1'b1);
            return;
        end
        if (int'(p) >= PORTS)
            return;
        case (b)
            ST_MTC, ST_SONG: open_message(p, b, 1);
            ST_SPP:          open_message(p, b, 2);
            ST_SYSEX:        open_message(p, b, SYSEX_BUDGET);
            ST_EOX: begin
                if (port_open[p]) begin
                    append_byte(p, b);
                    flush_message(p);
                end
            end
            default: begin
                if (b < DATA_LIMIT && port_open[p]) begin
                    append_byte(p, b);
                    if (port_need[p] > 0)
                        port_need[p] = port_need[p] - REM_W'(1);
                    if (port_need[p] == 0)
                        flush_message(p);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_byte(input t_out got);
        t_out want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected word port %0d byte %02h last %0b",
                                      got.out_port, got.out_byte, got.last));
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_port !== want.out_port || got.out_byte !== want.out_byte ||
                got.last !== want.last)
                report_mismatch($sformatf(
                    "got port %0d byte %02h last %0b, expected port %0d byte %02h last %0b",
                    got.out_port, got.out_byte, got.last,
                    want.out_port, want.out_byte, want.last));
        end
        bytes_checked++;
        if (got.last === 1'b1)
            messages_seen++;
    endtask

    always @(posedge i_clk) begin
        t_in  nxt_word;
        logic nxt_valid;
        if (i_rst_n) begin
            nxt_word  = i_in;
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                assemble_word(i_in);
                words_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_words.size() > 0 &&
                (calm_phase || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt_word  = pending_words.pop_front();
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
            i_in       <= nxt_word;
            calm_phase <= (words_taken >= CALM_FIRST && words_taken < CALM_LAST);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_byte(o_out);
            i_out_stall <= !calm_phase && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_word(input logic [3:0] p, input logic [7:0] b, input bit counts);
        t_in w;
        w.port      = p;
        w.data_byte = b;
        pending_words.insert(pending_words.size(), w);
        if (counts)
            planned_count++;
    endtask

    function automatic logic [7:0] pick_realtime();
        case ($urandom_range(0, 6))
            0:       return ST_TUNE;
            1:       return RT_CLOCK;
            2:       return RT_START;
            3:       return RT_CONT;
            4:       return RT_STOP;
            5:       return RT_SENSE;
            default: return RT_RESET;
        endcase
    endfunction

    function automatic logic [7:0] pick_ignored();
        case ($urandom_range(0, 4))
            0:       return ST_UNDEF_F4;
            1:       return ST_UNDEF_F5;
            2:       return ST_UNDEF_F9;
            3:       return ST_UNDEF_FD;
            default: return 8'($urandom_range(ST_NOTE_OFF, ST_PITCH_TOP));
        endcase
    endfunction

    function automatic logic [7:0] pick_opener();
        case ($urandom_range(0, 3))
            0:       return ST_SYSEX;
            1:       return ST_MTC;
            2:       return ST_SPP;
            default: return ST_SONG;
        endcase
    endfunction

    task automatic add_noise();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            add_word(4'($urandom_range(0, 15)), pick_realtime(), 1'b1);
        else if (k < 80)
            add_word(4'($urandom_range(0, 15)), pick_ignored(), 1'b0);
        else
            add_word(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic add_message(input logic [3:0] p, input logic [7:0] opener,
                               input int ndata, input bit eox, input bit noisy);
        add_word(p, opener, 1'b1);
        for (int i = 0; i < ndata; i++) begin
            if (noisy && $urandom_range(0, 99) < 15)
                add_noise();
            add_word(p, 8'($urandom_range(0, DATA_LIMIT - 1)), 1'b1);
        end
        if (eox)
            add_word(p, ST_EOX, 1'b1);
    endtask

    initial begin
        int         k;
        logic [3:0] p;
        logic [7:0] op;

        // Real-time bytes and tune request on their own.
        add_word(4'd0,  ST_TUNE,  1'b1);
        add_word(4'd15, RT_CLOCK, 1'b1);
        add_word(4'd1,  RT_START, 1'b1);
        add_word(4'd2,  RT_CONT,  1'b1);
        add_word(4'd9,  RT_STOP,  1'b1);
        add_word(4'd10, RT_SENSE, 1'b1);
        add_word(4'd15, RT_RESET, 1'b1);
        // Data and end of exclusive with nothing open are dropped.
        add_word(4'd15, 8'h05,  1'b1);
        add_word(4'd15, ST_EOX, 1'b1);
        // Short system common messages with unrelated status bytes inside.
        add_word(4'd3, ST_MTC,      1'b1);
        add_word(4'd3, ST_NOTE_OFF, 1'b1);
        add_word(4'd3, 8'h7F,       1'b1);
        add_word(4'd4, ST_SPP,      1'b1);
        add_word(4'd4, 8'h00,       1'b1);
        add_word(4'd4, ST_UNDEF_FD, 1'b1);
        add_word(4'd4, 8'h55,       1'b1);
        add_word(4'd5, ST_SONG,     1'b1);
        add_word(4'd5, ST_UNDEF_F4, 1'b1);
        add_word(4'd5, 8'h12,       1'b1);
        // Exclusive with a real-time byte inside, closed by end of exclusive.
        add_word(4'd6, ST_SYSEX,    1'b1);
        add_word(4'd6, 8'h01,       1'b1);
        add_word(4'd6, RT_CLOCK,    1'b1);
        add_word(4'd6, ST_UNDEF_F5, 1'b1);
        add_word(4'd6, ST_UNDEF_F9, 1'b1);
        add_word(4'd6, ST_EOX,      1'b1);
        // A new opener replaces the open message.
        add_word(4'd7, ST_SPP,       1'b1);
        add_word(4'd7, 8'h11,        1'b1);
        add_word(4'd7, ST_MTC,       1'b1);
        add_word(4'd7, ST_PITCH_TOP, 1'b1);
        add_word(4'd7, 8'h00,        1'b1);

        planned_count = 0;
        // Exclusive that spends its whole budget; the trailing end byte is dropped.
        p = 4'($urandom_range(0, 15));
        add_message(p, ST_SYSEX, SYSEX_BUDGET, 1'b0, 1'b0);
        add_word(p, ST_EOX, 1'b1);

        while (planned_count < RANDOM_ITEMS) begin
            k = $urandom_range(0, 99);
            p = 4'($urandom_range(0, 15));
            if (k < 25)
                add_message(p, ($urandom_range(0, 1) != 0) ? ST_MTC : ST_SONG, 1, 1'b0, 1'b1);
            else if (k < 40)
                add_message(p, ST_SPP, 2, 1'b0, 1'b1);
            else if (k < 58)
                add_message(p, ST_SYSEX, $urandom_range(0, 8), 1'b1, 1'b1);
            else if (k < 60)
                add_message(p, ST_SYSEX, $urandom_range(9, SYSEX_BUDGET - 1), 1'b1, 1'b1);
            else if (k < 72)
                add_noise();
            else if (k < 86) begin
                op = pick_opener();
                add_message(p, op, (op == ST_SPP) ? 1 : (op == ST_SYSEX) ? 3 : 0,
                            1'b0, 1'b1);
                if ($urandom_range(0, 1) != 0)
                    add_word(p, ST_EOX, 1'b1);
            end else
                add_word(p, 8'($urandom_range(0, 255)), 1'b0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || i_in_valid || expected_bytes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (directed cases, a full exclusive budget, random traffic).",
                 words_taken);
        $display("Checked %0d output words forming %0d messages.", bytes_checked,
                 messages_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mspa_pkg.sv
hw/rtl/mspa_front.sv
hw/rtl/mspa_queue.sv
hw/rtl/mspa_back.sv
hw/rtl/midi_system_message_assembler.sv
dv/midi_system_message_assembler_tb.sv
